// ----- rtl/core/scs_pkg.sv -----
// Shared types, constants and the microcode table of the serial clock divider search.
// Used by every module under rtl/core; depends on nothing.
package scs_pkg;

   localparam int SCS_MAX_DIVIDER  = 255;
   localparam int SCS_MAX_PRESCALE = 254;

   localparam int SRC_W   = 32;
   localparam int FRAME_W = 5;
   localparam int SIZE_W  = 4;
   localparam int WORD_W  = 16;
   localparam int FIELD_W = 8;

   // datapath operations, one per microcode step
   typedef enum logic [2:0] {
      OP_WAIT,
      OP_MUL,
      OP_TEST,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_EMIT
   } op_type;

   // branch conditions
   typedef enum logic [2:0] {
      C_ALWAYS,
      C_REQ,
      C_DONE,
      C_DIV_LAST,
      C_RSP_FREE
   } cond_type;

   // microcode addresses
   typedef enum logic [2:0] {
      S_WAIT,
      S_MUL,
      S_TEST,
      S_DIV_INIT,
      S_DIV_STEP,
      S_EMIT
   } step_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type tgt_true;
      step_type tgt_false;
   } ctrl_type;

   typedef struct packed {
      logic done;      // candidate met target, or search exhausted
      logic div_last;  // divider on its final step
   } status_type;

   function automatic ctrl_type scs_rom(input step_type step);
      ctrl_type c;
      unique case (step)
         S_WAIT:     c = '{OP_WAIT,     C_REQ,      S_MUL,      S_WAIT};
         S_MUL:      c = '{OP_MUL,      C_ALWAYS,   S_TEST,     S_TEST};
         S_TEST:     c = '{OP_TEST,     C_DONE,     S_DIV_INIT, S_MUL};
         S_DIV_INIT: c = '{OP_DIV_INIT, C_ALWAYS,   S_DIV_STEP, S_DIV_STEP};
         S_DIV_STEP: c = '{OP_DIV_STEP, C_DIV_LAST, S_EMIT,     S_DIV_STEP};
         S_EMIT:     c = '{OP_EMIT,     C_RSP_FREE, S_WAIT,     S_EMIT};
         default:    c = '{OP_WAIT,     C_ALWAYS,   S_WAIT,     S_WAIT};
      endcase
      return c;
   endfunction

endpackage

// ----- rtl/core/scs_sequencer.sv -----
// Microcode sequencer: step counter, control ROM lookup and conditional branch.
// Depends on scs_pkg.
module scs_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   rsp_stall,
   input  scs_pkg::status_type    status,
   output scs_pkg::op_type        op
);
   import scs_pkg::*;

   step_type step_ff;
   step_type step_in;
   ctrl_type ctrl;
   logic     take;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      ctrl = scs_rom(step_ff);
      unique case (ctrl.cond)
         C_ALWAYS:   take = 1'b1;
         C_REQ:      take = req_valid;
         C_DONE:     take = status.done;
         C_DIV_LAST: take = status.div_last;
         C_RSP_FREE: take = !rsp_stall;
         default:    take = 1'b1;
      endcase
      step_in = take ? ctrl.tgt_true : ctrl.tgt_false;
      op      = ctrl.op;
   end

endmodule

// ----- rtl/core/scs_datapath.sv -----
// Search datapath: captured request, prescale/divider walk, running modulus and
// the multiply-compare test of one candidate. Depends on scs_pkg.
module scs_datapath #(
   parameter int MAX_DIVIDER  = scs_pkg::SCS_MAX_DIVIDER,
   parameter int MAX_PRESCALE = scs_pkg::SCS_MAX_PRESCALE,
   parameter int KW           = $clog2((MAX_DIVIDER + 1) * MAX_PRESCALE + 1)
) (
   input  logic                          clock,
   input  scs_pkg::op_type               op,
   input  logic                          load,
   input  logic [scs_pkg::SRC_W-1:0]     source_clock_hz,
   input  logic [scs_pkg::SRC_W-1:0]     target_rate_hz,
   input  logic [scs_pkg::FRAME_W-1:0]   frame_bits,
   input  logic                          phase_second_edge,
   input  logic                          idle_high,
   output logic                          done,
   output logic [scs_pkg::SRC_W-1:0]     src,
   output logic [KW-1:0]                 modulus,
   output logic [scs_pkg::WORD_W-1:0]    control_word,
   output logic [scs_pkg::FIELD_W-1:0]   prescale_out,
   output logic [scs_pkg::FIELD_W-1:0]   divider_out,
   output logic                          unreachable
);
   import scs_pkg::*;

   localparam int DW     = $clog2(MAX_DIVIDER + 1);
   localparam int PW     = $clog2(MAX_PRESCALE + 1);
   localparam int PLAST  = MAX_PRESCALE - (MAX_PRESCALE % 2);
   localparam int PROD_W = SRC_W + 1 + KW;

   logic [SRC_W-1:0]  src_ff;
   logic [SRC_W-1:0]  tgt_ff;
   logic [SIZE_W-1:0] size_ff;
   logic              cpha_ff;
   logic              cpol_ff;
   logic [PW-1:0]     p_ff;
   logic [DW-1:0]     d_ff;
   logic [KW-1:0]     k_ff;
   logic [PROD_W-1:0] prod_ff;
   logic              miss_ff;

   logic d_last;
   logic p_last;
   logic hit;

   assign d_last = (d_ff == DW'(MAX_DIVIDER));
   assign p_last = (p_ff == PW'(PLAST));
   // floor(src/k) <= tgt  <=>  src < (tgt+1)*k
   assign hit    = (PROD_W'(src_ff) < prod_ff);
   assign done   = hit || (d_last && p_last);

   always_ff @(posedge clock) begin
      if (load) begin
         src_ff  <= source_clock_hz;
         tgt_ff  <= target_rate_hz;
         size_ff <= SIZE_W'(frame_bits - FRAME_W'(1));
         cpha_ff <= phase_second_edge;
         cpol_ff <= idle_high;
         p_ff    <= PW'(2);
         d_ff    <= '0;
         k_ff    <= KW'(2);
         miss_ff <= 1'b1;
      end
      case (op)
         OP_MUL: begin
            prod_ff <= PROD_W'({1'b0, tgt_ff} + (SRC_W + 1)'(1)) * PROD_W'(k_ff);
         end
         OP_TEST: begin
            if (hit) begin
               miss_ff <= 1'b0;
            end else if (!d_last) begin
               d_ff <= d_ff + DW'(1);
               k_ff <= k_ff + KW'(p_ff);
            end else if (!p_last) begin
               p_ff <= p_ff + PW'(2);
               d_ff <= '0;
               k_ff <= KW'(p_ff) + KW'(2);
            end
         end
         default: ;
      endcase
   end

   assign src          = src_ff;
   assign modulus      = k_ff;
   assign control_word = {FIELD_W'(d_ff), cpha_ff, cpol_ff, 2'b00, size_ff};
   assign prescale_out = FIELD_W'(p_ff);
   assign divider_out  = FIELD_W'(d_ff);
   assign unreachable  = miss_ff;

endmodule

// ----- rtl/core/scs_divider.sv -----
// Restoring divider, one quotient bit per cycle: src / modulus.
// Depends on scs_pkg.
module scs_divider #(
   parameter int KW = 16
) (
   input  logic                       clock,
   input  logic                       start,
   input  logic                       step,
   input  logic [scs_pkg::SRC_W-1:0]  dividend,
   input  logic [KW-1:0]              divisor,
   output logic [scs_pkg::SRC_W-1:0]  quotient,
   output logic                       last
);
   import scs_pkg::*;

   localparam int CW = $clog2(SRC_W);

   logic [SRC_W-1:0] quo_ff;
   logic [KW-1:0]    rem_ff;
   logic [CW-1:0]    cnt_ff;
   logic [KW:0]      rem_sh;
   logic             fits;

   // partial remainder stays below the divisor, so KW bits hold it
   assign rem_sh = {rem_ff, quo_ff[SRC_W-1]};
   assign fits   = (rem_sh >= {1'b0, divisor});
   assign last   = (cnt_ff == CW'(SRC_W - 1));

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (step) begin
         rem_ff <= fits ? KW'(rem_sh - {1'b0, divisor}) : rem_sh[KW-1:0];
         quo_ff <= {quo_ff[SRC_W-2:0], fits};
         cnt_ff <= cnt_ff + CW'(1);
      end
   end

   assign quotient = quo_ff;

endmodule

// ----- rtl/core/spi_clock_divider_search.sv -----
// Top level of the serial clock prescaler/divider search.
// Instantiates scs_sequencer, scs_datapath and scs_divider; depends on scs_pkg.
//
// Usage:
//   req_* carries one setup transaction: source clock, target rate, frame size,
//   clock phase and idle polarity. rsp_* returns one transaction: control word,
//   prescale, divider, reached rate and the unreachable flag.
//   A transaction moves at a rising edge with valid high and stall low.
// Operation:
//   The block works on one transaction at a time. req_stall is low only while
//   the sequencer waits for a request. Each candidate pair (even prescale from
//   2, divider 0..MAX_DIVIDER inner) is tested with a registered
//   (target+1)*modulus multiply, then the compare. After the search, a
//   restoring divider computes the reached rate. With the default limits the
//   search tries at most 127 prescales x 256 dividers; no new setup is taken
//   before the result transaction has moved.
// Reset: synchronous, returns the sequencer to its wait step; no result pending.
// Stall: while rsp_stall is high the result holds on rsp_* and no new request
//   is taken.
module spi_clock_divider_search #(
   parameter int MAX_DIVIDER  = scs_pkg::SCS_MAX_DIVIDER,
   parameter int MAX_PRESCALE = scs_pkg::SCS_MAX_PRESCALE
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [scs_pkg::SRC_W-1:0]     req_source_clock_hz,
   input  logic [scs_pkg::SRC_W-1:0]     req_target_rate_hz,
   input  logic [scs_pkg::FRAME_W-1:0]   req_frame_bits,
   input  logic                          req_phase_second_edge,
   input  logic                          req_idle_high,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [scs_pkg::WORD_W-1:0]    rsp_control_word,
   output logic [scs_pkg::FIELD_W-1:0]   rsp_prescale_out,
   output logic [scs_pkg::FIELD_W-1:0]   rsp_divider_out,
   output logic [scs_pkg::SRC_W-1:0]     rsp_reached_rate_hz,
   output logic                          rsp_unreachable
);
   import scs_pkg::*;

   // modulus (divider+1)*prescale width
   localparam int KW = $clog2((MAX_DIVIDER + 1) * MAX_PRESCALE + 1);

   op_type           op;
   status_type       status;
   logic             search_done;
   logic             div_last;
   logic             load;
   logic [SRC_W-1:0] src;
   logic [KW-1:0]    modulus;

   // request taken only in the wait step
   assign req_stall = (op != OP_WAIT);
   assign load      = req_valid && (op == OP_WAIT);
   assign rsp_valid = (op == OP_EMIT);
   assign status    = '{done: search_done, div_last: div_last};

   scs_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .op        (op)
   );

   scs_datapath #(
      .MAX_DIVIDER  (MAX_DIVIDER),
      .MAX_PRESCALE (MAX_PRESCALE),
      .KW           (KW)
   ) u_dp (
      .clock             (clock),
      .op                (op),
      .load              (load),
      .source_clock_hz   (req_source_clock_hz),
      .target_rate_hz    (req_target_rate_hz),
      .frame_bits        (req_frame_bits),
      .phase_second_edge (req_phase_second_edge),
      .idle_high         (req_idle_high),
      .done              (search_done),
      .src               (src),
      .modulus           (modulus),
      .control_word      (rsp_control_word),
      .prescale_out      (rsp_prescale_out),
      .divider_out       (rsp_divider_out),
      .unreachable       (rsp_unreachable)
   );

   // reached rate = src / ((divider+1)*prescale), final modulus held by datapath
   scs_divider #(
      .KW (KW)
   ) u_div (
      .clock    (clock),
      .start    (op == OP_DIV_INIT),
      .step     (op == OP_DIV_STEP),
      .dividend (src),
      .divisor  (modulus),
      .quotient (rsp_reached_rate_hz),
      .last     (div_last)
   );

endmodule

// ----- rtl/core/scs_checker.sv -----
// Port-level checks for spi_clock_divider_search, attached by bind.
// Depends on scs_pkg.
module scs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [scs_pkg::WORD_W-1:0]    rsp_control_word,
   input logic [scs_pkg::FIELD_W-1:0]   rsp_prescale_out,
   input logic [scs_pkg::FIELD_W-1:0]   rsp_divider_out,
   input logic [scs_pkg::SRC_W-1:0]     rsp_reached_rate_hz,
   input logic                          rsp_unreachable
);
   import scs_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_control_word)
         && $stable(rsp_reached_rate_hz) && $stable(rsp_unreachable))
      else $error("stalled result changed");

   // no new request while a result is pending
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request open while result pending");

   // control word carries the divider, reserved bits clear
   a_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_control_word[15:8] == rsp_divider_out)
         && (rsp_control_word[5:4] == 2'b00))
      else $error("control word inconsistent with divider");

   // prescale even and nonzero
   a_presc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_prescale_out[0] == 1'b0) && (rsp_prescale_out != 8'd0))
      else $error("prescale odd or zero");

endmodule

bind spi_clock_divider_search scs_checker u_scs_checker (.*);
